FILE: src/sidac_pkg.sv
// Shared types, constants and a helper function for the signed decimal ASCII converter.
package sidac_pkg;

   localparam int VALUE_BITS_DEFAULT = 32;

   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_MINUS = 8'd45;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SIGN,
      ST_DIGITS
   } sidac_state_type;

   typedef struct packed {
      logic load;
      logic next_digit;
   } sidac_ctl_type;

   typedef struct packed {
      logic       busy;
      logic [3:0] top_digit;
   } sidac_stat_type;

   // Decimal digits needed for a magnitude of up to 2^(bits-1).
   function automatic int digit_count(input int bits);
      digit_count = ((bits * 1233) >> 12) + 1;
   endfunction

endpackage

FILE: src/sidac_dabble.sv
// Bit-serial shift and add-3 binary to BCD unit with a digit shift-out path.
module sidac_dabble #(
   parameter int VALUE_BITS = sidac_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  sidac_pkg::sidac_ctl_type ctl,
   input  logic [VALUE_BITS-1:0]    mag,
   output sidac_pkg::sidac_stat_type stat
);

   localparam int NDIG  = sidac_pkg::digit_count(VALUE_BITS);
   localparam int BCDW  = NDIG * 4;
   localparam int CNTW  = $clog2(VALUE_BITS + 1);

   logic                  busy_ff, busy_in;
   logic [CNTW-1:0]       cnt_ff, cnt_in;
   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic [BCDW-1:0]       bcd_ff, bcd_in;
   logic [BCDW-1:0]       adj;

   always_comb begin
      for (int i = 0; i < NDIG; i++) begin
         adj[i*4 +: 4] = (bcd_ff[i*4 +: 4] >= 4'd5) ? bcd_ff[i*4 +: 4] + 4'd3
                                                    : bcd_ff[i*4 +: 4];
      end
   end

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      mag_in  = mag_ff;
      bcd_in  = bcd_ff;
      if (ctl.load) begin
         busy_in = 1'b1;
         cnt_in  = CNTW'(VALUE_BITS);
         mag_in  = mag;
         bcd_in  = '0;
      end else if (busy_ff) begin
         bcd_in  = {adj[BCDW-2:0], mag_ff[VALUE_BITS-1]};
         mag_in  = {mag_ff[VALUE_BITS-2:0], 1'b0};
         cnt_in  = cnt_ff - CNTW'(1);
         busy_in = (cnt_ff != CNTW'(1));
      end else if (ctl.next_digit) begin
         bcd_in  = {bcd_ff[BCDW-5:0], 4'd0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      mag_ff <= mag_in;
      bcd_ff <= bcd_in;
   end

   assign stat.busy      = busy_ff;
   assign stat.top_digit = bcd_ff[BCDW-1 -: 4];

endmodule

FILE: src/sidac_outreg.sv
// Output register for the character channel.
module sidac_outreg (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  logic [7:0] char_code,
   input  logic       last_char,
   output logic       ready,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_char_code,
   output logic       rsp_last_char
);

   logic       valid_ff, valid_in;
   logic [7:0] code_ff, code_in;
   logic       last_ff, last_in;

   assign ready = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      code_in  = code_ff;
      last_in  = last_ff;
      if (ready) begin
         valid_in = push;
         if (push) begin
            code_in = char_code;
            last_in = last_char;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      code_ff <= code_in;
      last_ff <= last_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_char_code = code_ff;
   assign rsp_last_char = last_ff;

endmodule

FILE: src/signed_int_to_decimal_ascii.sv
// Top level of the signed integer to decimal ASCII converter.
// After the input transaction the magnitude is converted to BCD, then a minus sign or the first
// of NDIG digits is registered; each skipped leading zero delays the first digit further.
// A new value is accepted only in idle, after the last digit position of the previous one; the BCD
// shift takes in the magnitude bit by bit, then one digit position a cycle, held while the output stalls.
// Reset is synchronous and active high; it empties the output register and returns to idle.
module signed_int_to_decimal_ascii #(
   parameter int VALUE_BITS = sidac_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [VALUE_BITS-1:0] req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_char_code,
   output logic                  rsp_last_char
);

   localparam int NDIG = sidac_pkg::digit_count(VALUE_BITS);
   localparam int DCW  = (NDIG > 1) ? $clog2(NDIG) : 1;

   sidac_pkg::sidac_state_type state_ff, state_in;
   logic                       neg_ff, neg_in;
   logic                       started_ff, started_in;
   logic [DCW-1:0]             dcnt_ff, dcnt_in;

   sidac_pkg::sidac_ctl_type   ctl;
   sidac_pkg::sidac_stat_type  stat;
   logic [VALUE_BITS-1:0]      mag;
   logic                       out_ready;
   logic                       push;
   logic [7:0]                 push_code;
   logic                       push_last;
   logic                       emit;

   assign mag = req_value[VALUE_BITS-1] ? (~req_value + VALUE_BITS'(1)) : req_value;
   assign req_stall = (state_ff != sidac_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sidac_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      neg_ff     <= neg_in;
      started_ff <= started_in;
      dcnt_ff    <= dcnt_in;
   end

   always_comb begin
      state_in       = state_ff;
      neg_in         = neg_ff;
      started_in     = started_ff;
      dcnt_in        = dcnt_ff;
      ctl.load       = 1'b0;
      ctl.next_digit = 1'b0;
      push           = 1'b0;
      push_code      = sidac_pkg::CHAR_ZERO + {4'd0, stat.top_digit};
      push_last      = (dcnt_ff == '0);
      emit           = (stat.top_digit != 4'd0) || started_ff || (dcnt_ff == '0);
      unique case (state_ff)
         sidac_pkg::ST_IDLE: begin
            if (req_valid) begin
               ctl.load = 1'b1;
               neg_in   = req_value[VALUE_BITS-1];
               state_in = sidac_pkg::ST_CONVERT;
            end
         end
         sidac_pkg::ST_CONVERT: begin
            if (!stat.busy) begin
               started_in = 1'b0;
               dcnt_in    = DCW'(NDIG - 1);
               state_in   = neg_ff ? sidac_pkg::ST_SIGN : sidac_pkg::ST_DIGITS;
            end
         end
         sidac_pkg::ST_SIGN: begin
            push_code = sidac_pkg::CHAR_MINUS;
            push_last = 1'b0;
            if (out_ready) begin
               push     = 1'b1;
               state_in = sidac_pkg::ST_DIGITS;
            end
         end
         sidac_pkg::ST_DIGITS: begin
            if (out_ready || !emit) begin
               push           = emit;
               ctl.next_digit = 1'b1;
               started_in     = emit;
               dcnt_in        = dcnt_ff - DCW'(1);
               if (dcnt_ff == '0) begin
                  state_in = sidac_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = sidac_pkg::ST_IDLE;
         end
      endcase
   end

   sidac_dabble #(
      .VALUE_BITS (VALUE_BITS)
   ) u_dabble (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .mag   (mag),
      .stat  (stat)
   );

   sidac_outreg u_outreg (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .char_code     (push_code),
      .last_char     (push_last),
      .ready         (out_ready),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_char_code (rsp_char_code),
      .rsp_last_char (rsp_last_char)
   );

endmodule

FILE: src/sidac_checker.sv
// Port-level checker for the signed decimal ASCII converter and its bind.
module sidac_checker #(
   parameter int VALUE_BITS = sidac_pkg::VALUE_BITS_DEFAULT
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic [VALUE_BITS-1:0] req_value,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [7:0]            rsp_char_code,
   input logic                  rsp_last_char
);

   logic value_seen;

   assign value_seen = (req_value == req_value);

   // A stalled result transaction keeps its character.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_char_code)
                                 && $stable(rsp_last_char))
      else $error("stalled result transaction changed");

   // The block takes one input transaction at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && value_seen |=> req_stall)
      else $error("input accepted while a conversion is running");

   // Every character is a minus sign or a decimal digit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_char_code == sidac_pkg::CHAR_MINUS)
                    || ((rsp_char_code >= sidac_pkg::CHAR_ZERO)
                        && (rsp_char_code <= sidac_pkg::CHAR_ZERO + 8'd9)))
      else $error("result character is not a sign or a digit");

   // A minus sign is never the final character.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_char_code == sidac_pkg::CHAR_MINUS) |-> !rsp_last_char)
      else $error("minus sign flagged as final character");

   // Reset leaves the block idle with no result pending.
   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

endmodule

bind signed_int_to_decimal_ascii sidac_checker #(
   .VALUE_BITS (VALUE_BITS)
) u_sidac_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_value     (req_value),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_char_code (rsp_char_code),
   .rsp_last_char (rsp_last_char)
);

FILE: tb/sidac_text_monitor.sv
// Monitor that predicts the decimal ASCII text of each accepted value and checks every character.
`timescale 1ns / 1ps

module sidac_text_monitor #(
   parameter int VALUE_BITS = sidac_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [VALUE_BITS-1:0] req_value,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [7:0]            rsp_char_code,
   input  logic                  rsp_last_char,
   output int                    pending,
   output int                    fail_count,
   output int                    chars_checked
);

   typedef struct packed {
      logic [7:0] code;
      logic       last;
   } ascii_char_type;

   ascii_char_type expected_chars[$];
   int pending_count = 0;
   int mismatch_count = 0;
   int checked_count = 0;

   assign pending = pending_count;
   assign fail_count = mismatch_count;
   assign chars_checked = checked_count;

   task automatic push_decimal_text(input logic [VALUE_BITS-1:0] value);
      logic [VALUE_BITS:0] magnitude;
      logic [3:0]          digits[$];
      logic                negative;
      int                  total;
      int                  k;
      ascii_char_type      ch;
      negative = value[VALUE_BITS-1];
      magnitude = negative ? ({1'b0, ~value} + 1'b1) : {1'b0, value};
      do begin
         digits.push_front(4'(magnitude % 10));
         magnitude = magnitude / 10;
      end while (magnitude != 0);
      total = digits.size() + (negative ? 1 : 0);
      k = 0;
      if (negative) begin
         ch.code = sidac_pkg::CHAR_MINUS;
         ch.last = (k == total - 1);
         expected_chars.push_back(ch);
         k++;
      end
      foreach (digits[i]) begin
         ch.code = sidac_pkg::CHAR_ZERO + 8'(digits[i]);
         ch.last = (k == total - 1);
         expected_chars.push_back(ch);
         k++;
      end
   endtask

   always @(posedge clock) begin
      ascii_char_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            push_decimal_text(req_value);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_chars.size() == 0) begin
               $error("Unexpected transaction: char_code %0d last_char %0d",
                      rsp_char_code, rsp_last_char);
               mismatch_count++;
            end else begin
               want = expected_chars.pop_front();
               checked_count++;
               if (rsp_char_code !== want.code) begin
                  $error("Mismatch on char_code: expected %0d, actual %0d",
                         want.code, rsp_char_code);
                  mismatch_count++;
               end
               if (rsp_last_char !== want.last) begin
                  $error("Mismatch on last_char: expected %0d, actual %0d",
                         want.last, rsp_last_char);
                  mismatch_count++;
               end
            end
         end
         pending_count = expected_chars.size();
      end
   end

endmodule

FILE: tb/tb_top.sv
// Top of the testbench: clock, reset, stimulus, stall generation and the final verdict.
`timescale 1ns / 1ps

module tb_top;

   localparam int VALUE_BITS = sidac_pkg::VALUE_BITS_DEFAULT;
   localparam int RANDOM_PER_PHASE = 49;
   localparam int DIRECTED_COUNT = 22;
   localparam logic [31:0] DIRECTED_VALUES [DIRECTED_COUNT] = '{
      32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10, 32'sd99, 32'sd100,
      32'sd2147483647, -32'sd2147483647, 32'h8000_0000, 32'sd1000000000,
      32'sd999999999, -32'sd999999999, -32'sd1000000000, 32'sd1234567890,
      -32'sd1234567890, 32'h5555_5555, 32'hAAAA_AAAA, 32'sd7, -32'sd5
   };

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [VALUE_BITS-1:0] req_value;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [7:0]            rsp_char_code;
   logic                  rsp_last_char;

   int pending;
   int fail_count;
   int chars_checked;
   int values_sent = 0;
   int stall_left = 0;
   bit no_idling = 0;

   signed_int_to_decimal_ascii #(
      .VALUE_BITS(VALUE_BITS)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_char_code(rsp_char_code),
      .rsp_last_char(rsp_last_char)
   );

   sidac_text_monitor #(
      .VALUE_BITS(VALUE_BITS)
   ) u_monitor (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_char_code(rsp_char_code),
      .rsp_last_char(rsp_last_char),
      .pending(pending),
      .fail_count(fail_count),
      .chars_checked(chars_checked)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("signed_int_to_decimal_ascii regression: fail");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idling || r < 50) begin
         return 0;
      end else if (r < 85) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(30, 80);
   endfunction

   always @(posedge clock) begin
      int r;
      logic next_stall;
      next_stall = 1'b0;
      if (stall_left > 0) begin
         stall_left--;
         next_stall = 1'b1;
      end else if (!no_idling) begin
         r = $urandom_range(0, 99);
         if (r >= 97) begin
            stall_left = $urandom_range(20, 60);
         end else if (r >= 88) begin
            stall_left = $urandom_range(4, 10);
         end else if (r >= 70) begin
            stall_left = $urandom_range(1, 3);
         end
         next_stall = (stall_left > 0);
         if (stall_left > 0) begin
            stall_left--;
         end
      end
      rsp_stall <= next_stall;
   end

   function automatic logic [31:0] random_value();
      int     kind;
      int     ndig;
      longint low_bound;
      longint high_bound;
      longint mag;
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
         return $urandom;
      end
      ndig = (kind < 8) ? $urandom_range(1, 10) : $urandom_range(1, 10);
      low_bound = 1;
      for (int i = 1; i < ndig; i++) begin
         low_bound = low_bound * 10;
      end
      if (kind < 8) begin
         high_bound = low_bound * 10 - 1;
         if (ndig == 1) begin
            low_bound = 0;
         end
         if (high_bound > 64'sd2147483647) begin
            high_bound = 64'sd2147483647;
         end
         mag = low_bound + (longint'($urandom) % (high_bound - low_bound + 1));
      end else begin
         mag = low_bound + $urandom_range(0, 2) - 1;
      end
      if ($urandom_range(0, 1) == 1) begin
         mag = -mag;
      end
      return mag[31:0];
   endfunction

   task automatic send_value(input logic [VALUE_BITS-1:0] value);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (req_stall);
      values_sent++;
   endtask

   task automatic wait_for_text();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_value = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         send_value(DIRECTED_VALUES[i]);
      end
      wait_for_text();

      for (int phase = 0; phase < 3; phase++) begin
         no_idling = (phase == 1);
         for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
            send_value(random_value());
         end
         wait_for_text();
      end
      no_idling = 1'b0;

      repeat (VALUE_BITS + 40) @(posedge clock);
      $display("Converted %0d values (zero, both extremes, 1 to 10 digits, both signs)",
               values_sent);
      $display("and checked %0d characters under random gaps and output stalls.",
               chars_checked);
      if (fail_count == 0) begin
         $display("signed_int_to_decimal_ascii regression: pass");
      end else begin
         $display("signed_int_to_decimal_ascii regression: fail");
      end
      $finish;
   end

endmodule

FILE: filelist.f
src/sidac_pkg.sv
src/sidac_dabble.sv
src/sidac_outreg.sv
src/signed_int_to_decimal_ascii.sv
src/sidac_checker.sv
tb/sidac_text_monitor.sv
tb/tb_top.sv
